// ===== sv/vala_pkg.sv =====
// ============================================================================
// vala_pkg
// Shared types, constants and helper functions for the eight-lane vector ALU.
// ============================================================================
package vala_pkg;

    // Fixed lane geometry and field widths.
    localparam int LANES         = 8;
    localparam int LANE_W        = 16;
    localparam int LANE_IDX_W    = 3;
    localparam int ROW_W         = LANES * LANE_W;
    localparam int HALF_W        = ROW_W / 2;
    localparam int OPCODE_W      = 4;
    localparam int ESEL_W        = 4;
    localparam int FLAGS_W       = 2 * LANES;
    localparam int REG_FIELD_W   = 5;
    localparam int REG_FIELD_DEP = 32;
    localparam int IDX_W_MAX     = 6;

    // Default register file depth.
    localparam int NUM_REGS_DEF  = 32;

    // Instruction codes.
    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD    = 4'd0,
        OP_SUB    = 4'd1,
        OP_ABS    = 4'd2,
        OP_ADDC   = 4'd3,
        OP_SUBC   = 4'd4,
        OP_AND    = 4'd5,
        OP_NAND   = 4'd6,
        OP_OR     = 4'd7,
        OP_NOR    = 4'd8,
        OP_XOR    = 4'd9,
        OP_XNOR   = 4'd10,
        OP_LWRITE = 4'd11
    } t_opcode;

    // One register row: eight 16-bit lanes, lane 0 in the low bits.
    typedef logic [LANES-1:0][LANE_W-1:0] t_row;

    // Per-lane result handed from a lane unit to the top level.
    typedef struct packed {
        logic [LANE_W-1:0] value;
        logic              carry;
        logic              ne;
    } t_lane_res;

    // Register index reduction table, one entry per encodable index.
    typedef logic [IDX_W_MAX-1:0] t_idx_tab [REG_FIELD_DEP];

    // Builds the index-modulo-depth table with a wrapping counter.
    function automatic t_idx_tab build_idx_tab(input int n);
        t_idx_tab tab;
        int       j;
        j = 0;
        for (int k = 0; k < REG_FIELD_DEP; k++) begin
            tab[k] = IDX_W_MAX'(j);
            j = (j + 1 == n) ? 0 : j + 1;
        end
        return tab;
    endfunction

    // Source lane of the second operand for destination lane i.
    function automatic logic [LANE_IDX_W-1:0] sel_lane(
        input logic [LANE_IDX_W-1:0] i,
        input logic [ESEL_W-1:0]     e
    );
        logic [LANE_IDX_W-1:0] l;
        if (e < 4'd2) begin
            l = i;
        end else if (e < 4'd4) begin
            l = {i[2:1], e[0]};
        end else if (e < 4'd8) begin
            l = {i[2], e[1:0]};
        end else begin
            l = e[2:0];
        end
        return l;
    endfunction

endpackage

// ===== sv/vector_add_logic_unit.sv =====
// ============================================================================
// vector_add_logic_unit
// Eight-lane 16-bit vector ALU with a register file, carry flags and an
// accumulator. One instruction per item, one result per item.
// ============================================================================
// Flow: the register file is read as an instruction is accepted, and the lane
// units fill the result register as the instruction leaves the operand stage.
// Throughput: one instruction per cycle; the input stalls only while a result
// waits in the result register and another instruction holds the operand stage.
// Reset: flags, accumulator and the per-row valid bits of the register file
// clear at reset, so every register reads as zero; no clearing pass.
module vector_add_logic_unit #(
    parameter int NUM_REGS = vala_pkg::NUM_REGS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Instruction channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [vala_pkg::OPCODE_W-1:0]     i_opcode,
    input  logic [vala_pkg::REG_FIELD_W-1:0]  i_dest_reg,
    input  logic [vala_pkg::REG_FIELD_W-1:0]  i_src_s_reg,
    input  logic [vala_pkg::REG_FIELD_W-1:0]  i_src_t_reg,
    input  logic [vala_pkg::ESEL_W-1:0]       i_element_sel,
    input  logic [vala_pkg::LANE_IDX_W-1:0]   i_write_lane,
    input  logic [vala_pkg::LANE_W-1:0]       i_write_value,
    // Result channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [vala_pkg::REG_FIELD_W-1:0]  o_written_reg,
    output logic [vala_pkg::HALF_W-1:0]       o_lanes_low,
    output logic [vala_pkg::HALF_W-1:0]       o_lanes_high,
    output logic [vala_pkg::FLAGS_W-1:0]      o_carry_flags,
    output logic [vala_pkg::HALF_W-1:0]       o_acc_low_lanes_low,
    output logic [vala_pkg::HALF_W-1:0]       o_acc_low_lanes_high
);
    import vala_pkg::*;

    localparam int       RW      = $clog2(NUM_REGS);
    localparam int       HALF_L  = LANES / 2;
    localparam t_idx_tab IDX_TAB = build_idx_tab(NUM_REGS);

    // Handshake.
    logic in_acc;
    logic s1_adv;

    // Reduced register indexes of the incoming instruction.
    logic [RW-1:0] idx_d;
    logic [RW-1:0] idx_s;
    logic [RW-1:0] idx_t;

    // Operand stage.
    logic              r_s1_valid;
    t_opcode           r_s1_op;
    logic [RW-1:0]     r_s1_d;
    logic [ESEL_W-1:0] r_s1_e;
    logic [LANE_IDX_W-1:0] r_s1_wl;
    logic [LANE_W-1:0] r_s1_wv;
    logic              r_s1_vld_s;
    logic              r_s1_vld_t;
    logic              r_s1_vld_d;
    logic              r_s1_fwd_s;
    logic              r_s1_fwd_t;
    logic              r_s1_fwd_d;
    t_row              r_s1_fwd_row;

    // Architectural state.
    logic [NUM_REGS-1:0] r_row_vld;
    logic [FLAGS_W-1:0]  r_carry;
    t_row                r_acc;

    // Output register.
    logic                   r_out_valid;
    logic [REG_FIELD_W-1:0] r_out_reg;
    t_row                   r_out_row;

    // Datapath.
    logic [ROW_W-1:0] q_s;
    logic [ROW_W-1:0] q_t;
    logic [ROW_W-1:0] q_d;
    t_row             a_row;
    t_row             t_row_src;
    t_row             d_row;
    t_row             b_row;
    t_lane_res        lane_res [LANES];
    t_row             n_row;
    logic [FLAGS_W-1:0] n_carry;
    t_row             n_acc;

    assign in_acc     = i_in_valid && o_in_ready;
    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;

    assign idx_d = IDX_TAB[i_dest_reg][RW-1:0];
    assign idx_s = IDX_TAB[i_src_s_reg][RW-1:0];
    assign idx_t = IDX_TAB[i_src_t_reg][RW-1:0];

    // Three copies of the register file, one per read port, written alike.
    vala_ram #(.WIDTH(ROW_W), .DEPTH(NUM_REGS)) u_ram_s (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_d),
        .i_wdata (ROW_W'(n_row)),
        .i_re    (in_acc),
        .i_raddr (idx_s),
        .o_rdata (q_s)
    );

    vala_ram #(.WIDTH(ROW_W), .DEPTH(NUM_REGS)) u_ram_t (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_d),
        .i_wdata (ROW_W'(n_row)),
        .i_re    (in_acc),
        .i_raddr (idx_t),
        .o_rdata (q_t)
    );

    vala_ram #(.WIDTH(ROW_W), .DEPTH(NUM_REGS)) u_ram_d (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_d),
        .i_wdata (ROW_W'(n_row)),
        .i_re    (in_acc),
        .i_raddr (idx_d),
        .o_rdata (q_d)
    );

    // Operand stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Operand stage payload. A row written at the accept edge is forwarded,
    // since the RAM read at that edge returns the old contents.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_op      <= t_opcode'(i_opcode);
            r_s1_d       <= idx_d;
            r_s1_e       <= i_element_sel;
            r_s1_wl      <= i_write_lane;
            r_s1_wv      <= i_write_value;
            r_s1_vld_s   <= r_row_vld[idx_s];
            r_s1_vld_t   <= r_row_vld[idx_t];
            r_s1_vld_d   <= r_row_vld[idx_d];
            r_s1_fwd_s   <= s1_adv && (idx_s == r_s1_d);
            r_s1_fwd_t   <= s1_adv && (idx_t == r_s1_d);
            r_s1_fwd_d   <= s1_adv && (idx_d == r_s1_d);
            r_s1_fwd_row <= n_row;
        end
    end

    // Operand selection: forwarded row, stored row, or zero for a row not
    // yet written since reset.
    always_comb begin
        if (r_s1_fwd_s) begin
            a_row = r_s1_fwd_row;
        end else begin
            a_row = r_s1_vld_s ? t_row'(q_s) : '0;
        end
        if (r_s1_fwd_t) begin
            t_row_src = r_s1_fwd_row;
        end else begin
            t_row_src = r_s1_vld_t ? t_row'(q_t) : '0;
        end
        if (r_s1_fwd_d) begin
            d_row = r_s1_fwd_row;
        end else begin
            d_row = r_s1_vld_d ? t_row'(q_d) : '0;
        end
    end

    // Element select and lane units.
    genvar gi;
    generate
        for (gi = 0; gi < LANES; gi++) begin : g_lane
            assign b_row[gi] = t_row_src[sel_lane(LANE_IDX_W'(gi), r_s1_e)];

            vala_lane u_lane (
                .i_op    (r_s1_op),
                .i_a     (a_row[gi]),
                .i_b     (b_row[gi]),
                .i_carry (r_carry[gi]),
                .o_res   (lane_res[gi])
            );
        end
    endgenerate

    // Next row, flags and accumulator.
    always_comb begin
        n_row   = d_row;
        n_carry = r_carry;
        n_acc   = r_acc;
        unique case (r_s1_op)
            OP_ADD, OP_SUB: begin
                for (int i = 0; i < LANES; i++) begin
                    n_row[i] = lane_res[i].value;
                end
                n_carry = '0;
            end
            OP_ABS: begin
                for (int i = 0; i < LANES; i++) begin
                    n_row[i] = lane_res[i].value;
                    n_acc[i] = lane_res[i].value;
                end
            end
            OP_ADDC, OP_SUBC: begin
                for (int i = 0; i < LANES; i++) begin
                    n_row[i]          = lane_res[i].value;
                    n_acc[i]          = lane_res[i].value;
                    n_carry[i]        = lane_res[i].carry;
                    n_carry[LANES + i] = lane_res[i].ne;
                end
            end
            OP_AND, OP_NAND, OP_OR, OP_NOR, OP_XOR, OP_XNOR: begin
                for (int i = 0; i < LANES; i++) begin
                    n_row[i] = lane_res[i].value;
                end
            end
            OP_LWRITE: begin
                n_row[r_s1_wl] = r_s1_wv;
            end
            default: begin
                // Unused codes rewrite the destination with its own contents.
                n_row = d_row;
            end
        endcase
    end

    // Architectural state update as the instruction retires.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_carry   <= '0;
            r_acc     <= '0;
        end else if (s1_adv) begin
            r_row_vld[r_s1_d] <= 1'b1;
            r_carry           <= n_carry;
            r_acc             <= n_acc;
        end
    end

    // Output register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_reg <= REG_FIELD_W'(r_s1_d);
            r_out_row <= n_row;
        end
    end

    // Flags and accumulator change only when a new result enters the output
    // register, so they always match the result on display.
    assign o_out_valid          = r_out_valid;
    assign o_written_reg        = r_out_reg;
    assign o_lanes_low          = r_out_row[HALF_L-1:0];
    assign o_lanes_high         = r_out_row[LANES-1:HALF_L];
    assign o_carry_flags        = r_carry;
    assign o_acc_low_lanes_low  = r_acc[HALF_L-1:0];
    assign o_acc_low_lanes_high = r_acc[LANES-1:HALF_L];

    // An accepted instruction occupies the operand stage next cycle.
    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_valid)
        else $error("accepted instruction did not reach the operand stage");

    // A retiring instruction always produces a visible result.
    a_retire_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_out_valid)
        else $error("retired instruction produced no result");

    // Saturating add and subtract leave the flags cleared.
    a_addsub_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && (r_s1_op == OP_ADD || r_s1_op == OP_SUB)) |=> (r_carry == '0))
        else $error("carry flags not cleared by add or subtract");

    // Flags and accumulator hold while nothing retires.
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!s1_adv && $past(i_rst_n)) |=> ($stable(r_carry) && $stable(r_acc)))
        else $error("flags or accumulator changed without a retiring instruction");

endmodule

// ===== sv/vala_ram.sv =====
// ============================================================================
// vala_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module vala_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds while no read is enabled.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/vala_lane.sv =====
// ============================================================================
// vala_lane
// One 16-bit lane of the vector ALU: saturating add/sub, conditional
// absolute value, add/subtract with carry flags and the logical ops.
// ============================================================================
module vala_lane (
    input  vala_pkg::t_opcode            i_op,
    input  logic [vala_pkg::LANE_W-1:0]  i_a,
    input  logic [vala_pkg::LANE_W-1:0]  i_b,
    input  logic                         i_carry,
    output vala_pkg::t_lane_res          o_res
);
    import vala_pkg::*;

    localparam int SUM_W = LANE_W + 2;
    localparam logic [LANE_W-1:0] MAX_POS = {1'b0, {(LANE_W-1){1'b1}}};
    localparam logic [LANE_W-1:0] MIN_NEG = {1'b1, {(LANE_W-1){1'b0}}};

    // Clamps an 18-bit signed value to the signed 16-bit range.
    function automatic logic [LANE_W-1:0] sat16(input logic [SUM_W-1:0] v);
        logic [LANE_W-1:0] s;
        if (v[SUM_W-1:LANE_W-1] == '0 || v[SUM_W-1:LANE_W-1] == '1) begin
            s = v[LANE_W-1:0];
        end else if (v[SUM_W-1]) begin
            s = MIN_NEG;
        end else begin
            s = MAX_POS;
        end
        return s;
    endfunction

    logic [SUM_W-1:0]  a_ext;
    logic [SUM_W-1:0]  b_ext;
    logic [SUM_W-1:0]  c_ext;
    logic [LANE_W:0]   u_sum;

    assign a_ext = {{2{i_a[LANE_W-1]}}, i_a};
    assign b_ext = {{2{i_b[LANE_W-1]}}, i_b};
    assign c_ext = SUM_W'(i_carry);
    assign u_sum = {1'b0, i_a} + {1'b0, i_b};

    // Lane operation select.
    always_comb begin
        o_res = '0;
        unique case (i_op)
            OP_ADD: begin
                o_res.value = sat16(a_ext + b_ext + c_ext);
            end
            OP_SUB: begin
                o_res.value = sat16(a_ext - b_ext - c_ext);
            end
            OP_ABS: begin
                // Negate on a negative first operand; the most negative value
                // maps to the largest positive one.
                if (i_a[LANE_W-1]) begin
                    o_res.value = (i_b == MIN_NEG) ? MAX_POS : (~i_b + 1'b1);
                end else if (i_a != '0) begin
                    o_res.value = i_b;
                end else begin
                    o_res.value = '0;
                end
            end
            OP_ADDC: begin
                o_res.value = u_sum[LANE_W-1:0];
                o_res.carry = u_sum[LANE_W];
                o_res.ne    = (u_sum[LANE_W-1:0] != '0);
            end
            OP_SUBC: begin
                // Borrow is an unsigned compare of the two operands.
                o_res.value = i_a - i_b;
                o_res.carry = (i_a < i_b);
                o_res.ne    = (i_a != i_b);
            end
            OP_AND:  o_res.value = i_a & i_b;
            OP_NAND: o_res.value = ~(i_a & i_b);
            OP_OR:   o_res.value = i_a | i_b;
            OP_NOR:  o_res.value = ~(i_a | i_b);
            OP_XOR:  o_res.value = i_a ^ i_b;
            OP_XNOR: o_res.value = ~(i_a ^ i_b);
            default: o_res = '0;
        endcase
    end

endmodule
